// ===== hdl/fbcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbcd_pkg
// Shared types and codes for the FIFO budget cache directory.
// ----------------------------------------------------------------------------
package fbcd_pkg;

  localparam int DEFAULT_DEPTH = 32;

  localparam int ID_W     = 31;
  localparam int SIZE_W   = 32;
  localparam int AGE_W    = 32;
  localparam int KIND_W   = 2;
  localparam int CLIM_W   = 6;
  localparam int BLIM_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int TDATA_W  = 64;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_EVICT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEARED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT  = 1'd1;

  typedef struct packed {
    logic [AGE_W-1:0]  age;
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage
`default_nettype wire

// ===== hdl/fifo_budget_cache_directory_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_budget_cache_directory_unit
// Insertion-ordered cache directory with an entry-count limit and a byte budget.
// ----------------------------------------------------------------------------
// Each insert may evict the oldest entries (one eviction result per entry) and
// then reports the item as stored or dropped with tlast set; a clear empties the
// table and reports once. Entries sit in a single-port-write, single-port-read
// memory with registered read data, and one compare unit walks it to find the
// oldest entry. Each eviction adds a scan of the live entries, a compare drain
// step, the result, and a read and write to move the last entry into the freed
// slot. The input is not ready until the last result is loaded into the output
// register; no clearing pass after reset.
// ----------------------------------------------------------------------------
module fifo_budget_cache_directory_unit #(
  parameter int TABLE_DEPTH = fbcd_pkg::DEFAULT_DEPTH
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [fbcd_pkg::TDATA_W-1:0]     in_tdata,   // item_id[30:0], item_size[62:31], 0
  input  wire                              in_tuser,   // func
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [fbcd_pkg::TDATA_W-1:0]     out_tdata,  // result_id[30:0], result_size[62:31], 0
  output logic [fbcd_pkg::KIND_W-1:0]      out_tuser,  // kind
  output logic                             out_tlast,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [fbcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [fbcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int TOTAL_W = fbcd_pkg::SIZE_W + CNT_W;
  localparam int LIM_W   = fbcd_pkg::CLIM_W + 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_SDONE   = 3'd3;
  localparam logic [2:0] S_EVICT   = 3'd4;
  localparam logic [2:0] S_MOVE_RD = 3'd5;
  localparam logic [2:0] S_MOVE_WR = 3'd6;
  localparam logic [2:0] S_FINAL   = 3'd7;

  logic [2:0]                    state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [TOTAL_W-1:0]            total_r, total_nxt;
  logic [fbcd_pkg::AGE_W-1:0]    age_r, age_nxt;
  logic [fbcd_pkg::CLIM_W-1:0]   clim_r;
  logic [fbcd_pkg::BLIM_W-1:0]   blim_r;

  logic                          func_r;
  logic [fbcd_pkg::ID_W-1:0]     id_r;
  logic [fbcd_pkg::SIZE_W-1:0]   size_r;

  logic [IDX_W-1:0]              scan_idx_r, scan_idx_nxt;
  logic                          cmp_vld_r;
  logic [IDX_W-1:0]              cmp_idx_r;
  logic                          found_r, found_nxt;
  logic [fbcd_pkg::AGE_W-1:0]    best_age_r, best_age_nxt;
  logic [IDX_W-1:0]              best_idx_r, best_idx_nxt;
  logic [fbcd_pkg::ID_W-1:0]     best_id_r, best_id_nxt;
  logic [fbcd_pkg::SIZE_W-1:0]   best_size_r, best_size_nxt;
  logic                          more_r, more_nxt;

  fbcd_pkg::entry_t              mem [TABLE_DEPTH];
  fbcd_pkg::entry_t              mem_q;
  fbcd_pkg::entry_t              mem_wd;
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_wa;
  logic [IDX_W-1:0]              rd_addr;

  logic                          out_tvalid_r;
  logic [fbcd_pkg::TDATA_W-1:0]  out_tdata_r;
  logic [fbcd_pkg::KIND_W-1:0]   out_tuser_r;
  logic                          out_tlast_r;
  logic                          out_free;
  logic                          out_ld;
  logic [fbcd_pkg::KIND_W-1:0]   ld_kind;
  logic [fbcd_pkg::ID_W-1:0]     ld_id;
  logic [fbcd_pkg::SIZE_W-1:0]   ld_size;
  logic                          ld_last;

  logic                          hit;
  logic                          over;
  logic                          drop;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;
  assign out_free   = !out_tvalid_r || out_tready;

  assign hit  = cmp_vld_r && (mem_q.age < best_age_r);
  assign over = (LIM_W'(count_r) > LIM_W'(clim_r)) ||
                (total_r > TOTAL_W'(blim_r));
  assign drop = (clim_r == '0) || (blim_r == '0) ||
                (LIM_W'(count_r) + LIM_W'(1) >= LIM_W'(clim_r)) ||
                (count_r >= CNT_W'(TABLE_DEPTH));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    age_nxt       = age_r;
    scan_idx_nxt  = scan_idx_r;
    found_nxt     = found_r;
    best_age_nxt  = best_age_r;
    best_idx_nxt  = best_idx_r;
    best_id_nxt   = best_id_r;
    best_size_nxt = best_size_r;
    more_nxt      = more_r;
    rd_addr       = scan_idx_r;
    mem_we        = 1'b0;
    mem_wa        = best_idx_r;
    mem_wd        = mem_q;
    out_ld        = 1'b0;
    ld_kind       = fbcd_pkg::KIND_EVICT;
    ld_id         = best_id_r;
    ld_size       = best_size_r;
    ld_last       = 1'b0;

    if (hit) begin
      found_nxt     = 1'b1;
      best_age_nxt  = mem_q.age;
      best_idx_nxt  = cmp_idx_r;
      best_id_nxt   = mem_q.id;
      best_size_nxt = mem_q.size;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (func_r == fbcd_pkg::FUNC_CLEAR || !over || count_r == '0) begin
          state_nxt = S_FINAL;
        end else begin
          state_nxt    = S_SCAN;
          scan_idx_nxt = '0;
          found_nxt    = 1'b0;
          best_age_nxt = age_r;
        end
      end
      S_SCAN: begin
        scan_idx_nxt = scan_idx_r + IDX_W'(1);
        if (scan_idx_r == IDX_W'(count_r - CNT_W'(1))) begin
          state_nxt = S_SDONE;
        end
      end
      S_SDONE: begin
        state_nxt = (found_r || hit) ? S_EVICT : S_FINAL;
      end
      S_EVICT: begin
        if (out_free) begin
          out_ld    = 1'b1;
          total_nxt = total_r - TOTAL_W'(best_size_r);
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_MOVE_RD;
        end
      end
      S_MOVE_RD: begin
        rd_addr   = IDX_W'(count_r);
        more_nxt  = (total_r > TOTAL_W'(blim_r)) && (best_size_r != '0);
        state_nxt = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        mem_we = 1'b1;
        if (more_r && count_r != '0) begin
          state_nxt    = S_SCAN;
          scan_idx_nxt = '0;
          found_nxt    = 1'b0;
          best_age_nxt = age_r;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          out_ld    = 1'b1;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
          if (func_r == fbcd_pkg::FUNC_CLEAR) begin
            ld_kind   = fbcd_pkg::KIND_CLEARED;
            ld_id     = '0;
            ld_size   = '0;
            count_nxt = '0;
            total_nxt = '0;
            age_nxt   = '0;
          end else begin
            ld_id   = id_r;
            ld_size = size_r;
            if (drop) begin
              ld_kind = fbcd_pkg::KIND_DROPPED;
            end else begin
              ld_kind   = fbcd_pkg::KIND_STORED;
              mem_we    = 1'b1;
              mem_wa    = IDX_W'(count_r);
              mem_wd    = '{age: age_r, size: size_r, id: id_r};
              count_nxt = count_r + CNT_W'(1);
              age_nxt   = age_r + fbcd_pkg::AGE_W'(1);
              total_nxt = total_r + TOTAL_W'(size_r);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      total_r      <= '0;
      age_r        <= '0;
      clim_r       <= '0;
      blim_r       <= '0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      more_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      total_r      <= total_nxt;
      age_r        <= age_nxt;
      cmp_vld_r    <= (state_r == S_SCAN);
      found_r      <= found_nxt;
      more_r       <= more_nxt;
      out_tvalid_r <= out_ld || (out_tvalid_r && !out_tready);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fbcd_pkg::REG_COUNT_LIMIT: clim_r <= cfg_data[fbcd_pkg::CLIM_W-1:0];
          fbcd_pkg::REG_BYTE_LIMIT:  blim_r <= cfg_data[fbcd_pkg::BLIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= in_tuser;
      id_r   <= in_tdata[fbcd_pkg::ID_W-1:0];
      size_r <= in_tdata[fbcd_pkg::ID_W +: fbcd_pkg::SIZE_W];
    end
    scan_idx_r  <= scan_idx_nxt;
    cmp_idx_r   <= scan_idx_r;
    best_age_r  <= best_age_nxt;
    best_idx_r  <= best_idx_nxt;
    best_id_r   <= best_id_nxt;
    best_size_r <= best_size_nxt;
    if (out_ld) begin
      out_tdata_r <= fbcd_pkg::TDATA_W'({ld_size, ld_id});
      out_tuser_r <= ld_kind;
      out_tlast_r <= ld_last;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_evict_not_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == fbcd_pkg::KIND_EVICT) |-> !out_tlast)
    else $error("eviction result marked last");

  a_evict_count : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVICT && out_free) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("eviction did not remove an entry");

  a_move_order : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE_WR) |-> ($past(state_r) == S_MOVE_RD))
    else $error("entry move written without its read");

endmodule
`default_nettype wire
